// ----- hw/rtl/ebrle_pkg.sv -----
// ----------------------------------------------------------------------------
// Escape-byte RLE decoder package
// Shared types and constants for the front parser, job queue and back packer.
// ----------------------------------------------------------------------------
package ebrle_pkg;

   // Default number of output bytes packed into one result
   localparam int BYTES_PER_RESULT_DEF = 4;

   // Depth of the job queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // Register widths
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 16;
   localparam int PRODUCED_W = 17;

   // Configuration register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_STOPPER  = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_EXPECTED = 1'd1;

   // Parser phase
   typedef enum logic [1:0] {
      PH_LITERAL = 2'd0,
      PH_COUNT   = 2'd1,
      PH_VALUE   = 2'd2
   } phase_type;

   // One expansion job handed from front to back
   typedef struct packed {
      logic [7:0] count;     // number of bytes to emit
      logic [7:0] value;     // byte to repeat
      logic       last;      // job closes the stream
      logic       mismatch;  // stream total differs from expected length
   } job_type;

endpackage

// ----- hw/rtl/ebrle_front.sv -----
// ----------------------------------------------------------------------------
// Escape-byte RLE decoder front end
// Holds the configuration registers, parses the compressed byte stream and
// turns each input transfer into at most one expansion job.
// ----------------------------------------------------------------------------
module ebrle_front (
   input  logic                               clock,
   input  logic                               reset,
   // configuration writes
   input  logic                               csr_we,
   input  logic [ebrle_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [ebrle_pkg::CSR_DATA_W-1:0]   csr_wdata,
   // compressed input
   input  logic                               in_valid,
   output logic                               in_ready,
   input  logic [7:0]                         in_byte,
   input  logic                               in_last,
   // job queue side
   input  logic                               queue_full,
   output logic                               push,
   output ebrle_pkg::job_type                 job
);

   logic [7:0]                          stopper_ff;
   logic [15:0]                         expected_ff;
   ebrle_pkg::phase_type                phase_ff, phase_in, phase_next;
   logic [7:0]                          run_ff, run_in;
   logic [ebrle_pkg::PRODUCED_W-1:0]    produced_ff, produced_in, total;
   logic [ebrle_pkg::PRODUCED_W:0]      sum;
   logic [7:0]                          n;
   logic [7:0]                          v;
   logic                                accept;

   assign in_ready = !queue_full;
   assign accept   = in_valid && in_ready;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         stopper_ff  <= '0;
         expected_ff <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            ebrle_pkg::REG_STOPPER:  stopper_ff  <= csr_wdata[7:0];
            ebrle_pkg::REG_EXPECTED: expected_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Next parser phase
   always_comb begin
      phase_next = ebrle_pkg::PH_LITERAL;
      case (phase_ff)
         ebrle_pkg::PH_COUNT: begin
            phase_next = in_last ? ebrle_pkg::PH_LITERAL : ebrle_pkg::PH_VALUE;
         end
         ebrle_pkg::PH_VALUE: begin
            phase_next = ebrle_pkg::PH_LITERAL;
         end
         default: begin
            if (in_byte == stopper_ff && !in_last) begin
               phase_next = ebrle_pkg::PH_COUNT;
            end
         end
      endcase
   end

   // Job contents for the current byte
   always_comb begin
      n      = '0;
      v      = '0;
      run_in = run_ff;
      case (phase_ff)
         ebrle_pkg::PH_COUNT: begin
            run_in = in_byte;
            if (in_last) begin
               n = in_byte;   // run cut short: value taken as zero
            end
         end
         ebrle_pkg::PH_VALUE: begin
            n = run_ff;
            v = in_byte;
         end
         default: begin
            if (in_byte != stopper_ff) begin
               n = 8'd1;
               v = in_byte;
            end
         end
      endcase
   end

   // Saturating stream byte total
   assign sum   = {1'b0, produced_ff} + (ebrle_pkg::PRODUCED_W+1)'(n);
   assign total = sum[ebrle_pkg::PRODUCED_W] ? '1 : sum[ebrle_pkg::PRODUCED_W-1:0];

   assign job.count    = n;
   assign job.value    = v;
   assign job.last     = in_last;
   assign job.mismatch = in_last
                         && (total != ebrle_pkg::PRODUCED_W'(expected_ff));

   // Jobs that make no result are dropped here
   assign push = accept && (n != 8'd0 || in_last);

   // Parser state update; end of stream returns to the reset state
   always_comb begin
      phase_in    = phase_ff;
      produced_in = produced_ff;
      if (accept) begin
         phase_in    = phase_next;
         produced_in = in_last ? '0 : total;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= ebrle_pkg::PH_LITERAL;
         run_ff      <= '0;
         produced_ff <= '0;
      end else begin
         phase_ff    <= phase_in;
         run_ff      <= (accept && in_last) ? '0 : (accept ? run_in : run_ff);
         produced_ff <= produced_in;
      end
   end

endmodule

// ----- hw/rtl/ebrle_queue.sv -----
// ----------------------------------------------------------------------------
// Escape-byte RLE decoder job queue
// Small register FIFO of expansion jobs between the front and the back.
// ----------------------------------------------------------------------------
module ebrle_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ebrle_pkg::job_type  push_job,
   input  logic                pop,
   output ebrle_pkg::job_type  head,
   output logic                empty,
   output logic                full
);

   localparam int PtrW = $clog2(ebrle_pkg::QUEUE_DEPTH);
   localparam int CntW = $clog2(ebrle_pkg::QUEUE_DEPTH + 1);

   ebrle_pkg::job_type  slot_ff [ebrle_pkg::QUEUE_DEPTH];
   logic [PtrW-1:0]     wr_ff, rd_ff;
   logic [CntW-1:0]     fill_ff;
   logic                do_push, do_pop;

   assign empty   = (fill_ff == '0);
   assign full    = (fill_ff == CntW'(ebrle_pkg::QUEUE_DEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = slot_ff[rd_ff];

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_job;
      end
   end

   // Pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ff <= (wr_ff == PtrW'(ebrle_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ff <= (rd_ff == PtrW'(ebrle_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         end
         case ({do_push, do_pop})
            2'b10:   fill_ff <= fill_ff + 1'b1;
            2'b01:   fill_ff <= fill_ff - 1'b1;
            default: fill_ff <= fill_ff;
         endcase
      end
   end

endmodule

// ----- hw/rtl/ebrle_back.sv -----
// ----------------------------------------------------------------------------
// Escape-byte RLE decoder back end
// Expands the job at the queue head into packed results, one result per
// cycle into the output register while the receiver does not stall it.
// ----------------------------------------------------------------------------
module ebrle_back #(
   parameter int BYTES_PER_RESULT = ebrle_pkg::BYTES_PER_RESULT_DEF
) (
   input  logic                clock,
   input  logic                reset,
   // job queue side
   input  ebrle_pkg::job_type  head,
   input  logic                empty,
   output logic                pop,
   // result side
   output logic                out_valid,
   input  logic                out_ready,
   output logic [31:0]         out_bytes,
   output logic [2:0]          byte_count,
   output logic                run_end,
   output logic                stream_end,
   output logic                length_mismatch
);

   localparam int CntW = $clog2(BYTES_PER_RESULT + 1);
   localparam logic [7:0] Bpr = 8'(BYTES_PER_RESULT);

   logic               started_ff, started_in;
   logic [7:0]         rem_ff, rem_in;
   logic [7:0]         remaining;
   logic               fits;
   logic [CntW-1:0]    cnt;
   logic [31:0]        word;
   logic               slot_free;
   logic               emit;
   logic               valid_ff;
   logic [31:0]        bytes_ff;
   logic [2:0]         count_ff;
   logic               run_end_ff, stream_end_ff, mismatch_ff;

   assign slot_free = !valid_ff || out_ready;
   assign emit      = slot_free && !empty;

   // Bytes still owed by the head job
   assign remaining = started_ff ? rem_ff : head.count;
   assign fits      = (remaining <= Bpr);
   assign cnt       = fits ? CntW'(remaining) : CntW'(BYTES_PER_RESULT);
   assign pop       = emit && fits;

   // Pack the repeated byte into the low lanes
   always_comb begin
      word = '0;
      for (int j = 0; j < 4; j++) begin
         if (CntW'(j) < cnt) begin
            word[8*j +: 8] = head.value;
         end
      end
   end

   always_comb begin
      started_in = started_ff;
      rem_in     = rem_ff;
      if (emit) begin
         started_in = !fits;
         rem_in     = remaining - Bpr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         started_ff <= started_in;
         if (slot_free) begin
            valid_ff <= !empty;
         end
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      if (emit) begin
         bytes_ff      <= word;
         count_ff      <= cnt[2:0];
         run_end_ff    <= fits;
         stream_end_ff <= fits && head.last;
         mismatch_ff   <= fits && head.mismatch;
      end
   end

   assign out_valid       = valid_ff;
   assign out_bytes       = bytes_ff;
   assign byte_count      = count_ff;
   assign run_end         = run_end_ff;
   assign stream_end      = stream_end_ff;
   assign length_mismatch = mismatch_ff;

endmodule

// ----- hw/rtl/escape_byte_rle_decoder_top.sv -----
// ----------------------------------------------------------------------------
// Escape-byte RLE decoder
// Expands an escape-coded compressed byte stream into packed output bytes.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  carries one compressed byte per transfer; req_tlast marks the
//          final byte of a stream.
//   rsp_*  carries packed results: BYTES_PER_RESULT bytes at most, the first
//          in the low bits; rsp_tlast marks the last result of one input
//          byte, rsp_tuser flags the end of stream and the length check.
//   csr_*  writes the stopper byte (index 0) and expected length (index 1);
//          write only while the block is idle.
// Timing:
//   A result passes through the job queue and the result register after the
//   input transfer that caused it. Literal bytes flow at one per cycle while
//   the receiver keeps up. A run of n bytes makes ceil(n / BYTES_PER_RESULT)
//   results, or one empty one if n is zero and closes the stream; a four-entry
//   job queue lets the front keep taking bytes, and req_tready falls when full.
//   A stalled receiver holds the result register and backs up the queue.
// Reset clears the parser, the queue and the output valid; no clearing pass.
// ----------------------------------------------------------------------------
module escape_byte_rle_decoder_top #(
   parameter int BYTES_PER_RESULT = ebrle_pkg::BYTES_PER_RESULT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // configuration
   input  logic                              csr_we,
   input  logic [ebrle_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [ebrle_pkg::CSR_DATA_W-1:0]  csr_wdata,
   // compressed input
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // in_byte[7:0]
   input  logic                              req_tlast,   // stream_last
   // decoded output
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [39:0]                       rsp_tdata,   // out_bytes[31:0], byte_count[34:32]
   output logic                              rsp_tlast,   // run_end
   output logic [1:0]                        rsp_tuser    // stream_end[0], length_mismatch[1]
);

   ebrle_pkg::job_type  push_job, head;
   logic                push, pop, q_empty, q_full;
   logic [31:0]         out_bytes;
   logic [2:0]          byte_count;
   logic                stream_end, length_mismatch;

   ebrle_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_byte    (req_tdata),
      .in_last    (req_tlast),
      .queue_full (q_full),
      .push       (push),
      .job        (push_job)
   );

   ebrle_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (head),
      .empty    (q_empty),
      .full     (q_full)
   );

   ebrle_back #(
      .BYTES_PER_RESULT (BYTES_PER_RESULT)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .empty           (q_empty),
      .pop             (pop),
      .out_valid       (rsp_tvalid),
      .out_ready       (rsp_tready),
      .out_bytes       (out_bytes),
      .byte_count      (byte_count),
      .run_end         (rsp_tlast),
      .stream_end      (stream_end),
      .length_mismatch (length_mismatch)
   );

   assign rsp_tdata = {5'b0, byte_count, out_bytes};
   assign rsp_tuser = {length_mismatch, stream_end};

   // End of stream only on the last result of a run
   a_stream_end_is_run_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && stream_end |-> rsp_tlast)
      else $error("stream end without run end");

   // Length check only reported with end of stream
   a_mismatch_with_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && length_mismatch |-> stream_end)
      else $error("length mismatch outside end of stream");

   // Results before the end of a run are always full
   a_full_chunks: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> byte_count == 3'(BYTES_PER_RESULT))
      else $error("short result before run end");

   // Queue status is consistent
   a_queue_status: assert property (@(posedge clock) disable iff (reset)
      !(q_empty && q_full))
      else $error("queue empty and full together");

endmodule

// ----- tb/escape_byte_rle_decoder_top_tb.sv -----
// ----------------------------------------------------------------------------
// Escape-byte RLE decoder testbench
// Drives compressed byte streams into the decoder and checks each result
// against a directed row's expected word or a cycle-free predictor. The table
// covers reset values, extremes and end-of-stream corners. Random streams with
// random gaps and stalls (none in one phase) follow under several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module escape_byte_rle_decoder_top_tb;

   localparam int             PACK          = ebrle_pkg::BYTES_PER_RESULT_DEF;
   localparam logic [16:0]    TOTAL_MAX     = 17'h1FFFF;
   localparam int             DRAIN_SLACK   = 8;
   localparam int             TAIL_CYCLES   = 16;
   localparam int             QUIET_LIMIT   = 2000;
   localparam int             MAX_PRINTS    = 40;
   localparam int             RANDOM_PHASES = 6;
   localparam int             PHASE_BYTES   = 34;

   // One decoded result, as seen on the rsp side
   typedef struct packed {
      logic [31:0] data;
      logic [2:0]  nbytes;
      logic        run_end;
      logic        stream_end;
      logic        mismatch;
   } decoded_word_type;

   typedef enum logic { ROW_ITEM, ROW_CONFIG } row_kind_type;

   typedef struct {
      row_kind_type     kind;
      logic [7:0]       b;       // compressed byte, or stopper for a config row
      logic             l;       // stream_last
      logic [15:0]      len;     // expected length for a config row
      bit               typed;   // word holds the expected result
      decoded_word_type word;
   } plan_row_type;

   typedef struct {
      logic [7:0] b;
      logic       l;
   } in_item_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             csr_we = 1'b0;
   logic [ebrle_pkg::CSR_ADDR_W-1:0] csr_addr = '0;
   logic [ebrle_pkg::CSR_DATA_W-1:0] csr_wdata = '0;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [7:0]                       req_tdata = '0;
   logic                             req_tlast = 1'b0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [39:0]                      rsp_tdata;
   logic                             rsp_tlast;
   logic [1:0]                       rsp_tuser;

   // Predictor state and its copy of the registers
   ebrle_pkg::phase_type  dec_phase = ebrle_pkg::PH_LITERAL;
   logic [7:0]            run_len = '0;
   logic [16:0]           stream_total = '0;
   logic [7:0]            cfg_stopper = '0;
   logic [15:0]           cfg_expected = '0;

   decoded_word_type      pending_words[$];
   decoded_word_type      latest_words[$];
   plan_row_type          plan_rows[$];
   in_item_type           stream_bytes[$];

   bit                    idle_on = 1'b1;
   int                    errors = 0;
   int                    results_seen = 0;
   int                    quiet_cycles = 0;

   escape_byte_rle_decoder_top #(
      .BYTES_PER_RESULT (PACK)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Mismatch reporting; printing is capped, counting is not
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (errors < MAX_PRINTS) begin
         $display("%0t result %0d: %s got %h expected %h", $time, results_seen,
                  what, got, want);
      end
      errors++;
   endtask

   // Decode one compressed byte into latest_words
   task automatic expand_byte(input logic [7:0] b, input logic l);
      logic [8:0]       n;
      logic [7:0]       v;
      int               left;
      int               take;
      decoded_word_type w;
      n = '0;
      v = '0;
      latest_words.delete();
      case (dec_phase)
         ebrle_pkg::PH_COUNT: begin
            run_len   = b;
            dec_phase = ebrle_pkg::PH_VALUE;
            // count with no value byte: run of zeros
            if (l) begin
               n = {1'b0, b};
            end
         end
         ebrle_pkg::PH_VALUE: begin
            n         = {1'b0, run_len};
            v         = b;
            dec_phase = ebrle_pkg::PH_LITERAL;
         end
         default: begin
            if (b != cfg_stopper) begin
               n = 9'd1;
               v = b;
            end else begin
               dec_phase = ebrle_pkg::PH_COUNT;
            end
         end
      endcase

      // saturating stream byte counter
      if (TOTAL_MAX - stream_total < {8'd0, n}) begin
         stream_total = TOTAL_MAX;
      end else begin
         stream_total = stream_total + {8'd0, n};
      end

      left = int'(n);
      while (left > 0) begin
         take = (left > PACK) ? PACK : left;
         w = '0;
         for (int j = 0; j < take && j < 4; j++) begin
            w.data[8*j +: 8] = v;
         end
         w.nbytes  = 3'(take);
         w.run_end = (left == take);
         latest_words.push_back(w);
         left -= take;
      end

      // close the stream: empty marker if nothing came out, then the check
      if (l) begin
         if (latest_words.size() == 0) begin
            w = '0;
            w.run_end = 1'b1;
            latest_words.push_back(w);
         end
         w = latest_words.pop_back();
         w.stream_end = 1'b1;
         w.mismatch   = (stream_total != {1'b0, cfg_expected});
         latest_words.push_back(w);
         dec_phase    = ebrle_pkg::PH_LITERAL;
         run_len      = '0;
         stream_total = '0;
      end
   endtask

   // One transfer on req; the random gap lowers tvalid only when it is taken
   task automatic send_byte(input logic [7:0] b, input logic l, input bit typed,
                            input decoded_word_type word);
      int gap;
      gap = idle_on ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= l;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expand_byte(b, l);
      if (typed) begin
         pending_words.push_back(word);
      end else begin
         foreach (latest_words[i]) pending_words.push_back(latest_words[i]);
      end
   endtask

   task automatic wait_drained();
      while (pending_words.size() != 0) @(posedge clock);
   endtask

   // Register writes only with the block idle, between streams
   task automatic apply_config(input logic [7:0] stopper, input logic [15:0] len);
      req_tvalid <= 1'b0;
      wait_drained();
      repeat (DRAIN_SLACK) @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= ebrle_pkg::REG_STOPPER;
      csr_wdata <= {8'd0, stopper};
      @(posedge clock);
      cfg_stopper = stopper;
      csr_addr  <= ebrle_pkg::REG_EXPECTED;
      csr_wdata <= len;
      @(posedge clock);
      cfg_expected = len;
      csr_we    <= 1'b0;
   endtask

   function automatic void add_item(input logic [7:0] b, input logic l);
      plan_rows.push_back('{ROW_ITEM, b, l, 16'd0, 1'b0, decoded_word_type'('0)});
   endfunction

   function automatic void add_checked(input logic [7:0] b, input logic l,
                                       input logic [31:0] data, input logic [2:0] nb,
                                       input logic re, input logic se, input logic mm);
      plan_rows.push_back('{ROW_ITEM, b, l, 16'd0, 1'b1,
                            decoded_word_type'({data, nb, re, se, mm})});
   endfunction

   function automatic void add_config(input logic [7:0] stopper, input logic [15:0] len);
      plan_rows.push_back('{ROW_CONFIG, stopper, 1'b0, len, 1'b0, decoded_word_type'('0)});
   endfunction

   function automatic logic [7:0] draw_count();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return 8'($urandom_range(0, 8));
      if (r < 9) return 8'($urandom_range(9, 40));
      return 8'($urandom_range(0, 255));
   endfunction

   // Random streams: mostly literals and complete runs, some noise, and
   // some streams cut off after a stopper or a count
   task automatic build_streams(input int target);
      int          ntok;
      int          kind;
      bit          broken;
      logic [7:0]  lit;
      in_item_type it;
      stream_bytes.delete();
      while (stream_bytes.size() < target) begin
         ntok   = $urandom_range(0, 6);
         broken = ($urandom_range(0, 6) == 0) || (ntok == 0);
         repeat (ntok) begin
            kind = $urandom_range(0, 99);
            if (kind < 45) begin
               do lit = 8'($urandom); while (lit == cfg_stopper);
               stream_bytes.push_back('{lit, 1'b0});
            end else if (kind < 90) begin
               stream_bytes.push_back('{cfg_stopper, 1'b0});
               stream_bytes.push_back('{draw_count(), 1'b0});
               lit = ($urandom_range(0, 9) == 0) ? cfg_stopper : 8'($urandom);
               stream_bytes.push_back('{lit, 1'b0});
            end else begin
               stream_bytes.push_back('{8'($urandom), 1'b0});
            end
         end
         if (broken) begin
            stream_bytes.push_back('{cfg_stopper, 1'b0});
            if ($urandom_range(0, 1) == 1) stream_bytes.push_back('{draw_count(), 1'b0});
         end
         it = stream_bytes.pop_back();
         it.l = 1'b1;
         stream_bytes.push_back(it);
      end
   endtask

   // Result side: random stall per result, check against the oldest expectation
   initial begin
      decoded_word_type got;
      decoded_word_type want;
      int               stall;
      forever begin
         stall = idle_on ? $urandom_range(0, 11) : 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (reset || rsp_tvalid !== 1'b1) @(posedge clock);
         got = {rsp_tdata[31:0], rsp_tdata[34:32], rsp_tlast, rsp_tuser[0], rsp_tuser[1]};
         if (pending_words.size() == 0) begin
            report_mismatch("unexpected result, out_bytes", got.data, 32'd0);
         end else begin
            want = pending_words.pop_front();
            if (got.data !== want.data) report_mismatch("out_bytes", got.data, want.data);
            if (got.nbytes !== want.nbytes) begin
               report_mismatch("byte_count", 32'(got.nbytes), 32'(want.nbytes));
            end
            if (got.run_end !== want.run_end) begin
               report_mismatch("run_end", 32'(got.run_end), 32'(want.run_end));
            end
            if (got.stream_end !== want.stream_end) begin
               report_mismatch("stream_end", 32'(got.stream_end), 32'(want.stream_end));
            end
            if (got.mismatch !== want.mismatch) begin
               report_mismatch("length_mismatch", 32'(got.mismatch), 32'(want.mismatch));
            end
         end
         results_seen++;
      end
   end

   // Watchdog: cycles with no transfer on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("** escape_byte_rle_decoder_top: FAILED **");
            $finish;
         end
      end
   end

   // Stimulus
   initial begin
      // reset values: stopper 0, expected length 0
      add_checked(8'h00, 1'b1, 32'h0, 3'd0, 1'b1, 1'b1, 1'b0); // lone stopper ends stream
      add_checked(8'hFF, 1'b0, 32'hFF, 3'd1, 1'b1, 1'b0, 1'b0);
      add_checked(8'h01, 1'b0, 32'h01, 3'd1, 1'b1, 1'b0, 1'b0);
      add_item(8'h00, 1'b0);                                    // zero count, value is stopper
      add_item(8'h00, 1'b0);
      add_item(8'h00, 1'b0);
      add_item(8'h00, 1'b0);                                    // longest run
      add_item(8'hFF, 1'b0);
      add_item(8'h5A, 1'b0);
      add_item(8'h00, 1'b0);
      add_item(8'h05, 1'b0);
      add_item(8'h80, 1'b1);
      add_item(8'h00, 1'b0);                                    // count cut off by the end
      add_checked(8'h03, 1'b1, 32'h0, 3'd3, 1'b1, 1'b1, 1'b1);
      add_checked(8'h7F, 1'b1, 32'h7F, 3'd1, 1'b1, 1'b1, 1'b1);
      add_config(8'hFF, 16'd4);
      add_checked(8'h00, 1'b0, 32'h00, 3'd1, 1'b1, 1'b0, 1'b0);
      add_item(8'hFF, 1'b0);
      add_item(8'h03, 1'b0);
      add_checked(8'h00, 1'b1, 32'h0, 3'd3, 1'b1, 1'b1, 1'b0); // total matches
      add_checked(8'hFF, 1'b1, 32'h0, 3'd0, 1'b1, 1'b1, 1'b1); // empty stream
      add_item(8'hFF, 1'b0);
      add_item(8'h04, 1'b0);
      add_checked(8'h11, 1'b1, 32'h11111111, 3'd4, 1'b1, 1'b1, 1'b0);
      add_item(8'hFF, 1'b0);
      add_checked(8'h00, 1'b1, 32'h0, 3'd0, 1'b1, 1'b1, 1'b1); // zero count at the end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (plan_rows[i]) begin
         if (plan_rows[i].kind == ROW_CONFIG) begin
            apply_config(plan_rows[i].b, plan_rows[i].len);
         end else begin
            send_byte(plan_rows[i].b, plan_rows[i].l, plan_rows[i].typed, plan_rows[i].word);
         end
      end

      // random phases, each under its own register setting
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph)
            0:       apply_config(8'hFF, 16'hFFFF);
            1:       apply_config(8'h00, 16'd0);
            2:       apply_config(8'($urandom), 16'($urandom_range(0, 40)));
            4:       apply_config(8'h80, 16'($urandom_range(0, 40)));
            default: apply_config(8'($urandom), 16'($urandom));
         endcase
         idle_on = (ph != 2);
         build_streams(PHASE_BYTES);
         foreach (stream_bytes[i]) begin
            send_byte(stream_bytes[i].b, stream_bytes[i].l, 1'b0, decoded_word_type'('0));
         end
      end

      req_tvalid <= 1'b0;
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("** escape_byte_rle_decoder_top: PASSED **");
      end else begin
         $display("** escape_byte_rle_decoder_top: FAILED **");
      end
      $finish;
   end

endmodule
